FILE: design/rfp_pkg.sv
// Package for the range frame parser: frame constants, status codes,
// number-collection state type and the fraction weight table.
// No dependencies.
package rfp_pkg;

    localparam int unsigned POS_W   = 7;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned FRAC_W  = 3;
    localparam int unsigned ACC_W   = 32;
    localparam int unsigned SUM_W   = 36;

    localparam logic [POS_W-1:0] MAX_FRAME = 7'd20;
    localparam logic [POS_W-1:0] MIN_FRAME = 7'd11;
    localparam logic [CNT_W-1:0] MAX_CHARS = 4'd11;
    localparam logic [FRAC_W-1:0] FRAC_LIMIT = 3'd4;

    localparam logic [POS_W-1:0] POS_ADDR  = 7'd0;
    localparam logic [POS_W-1:0] POS_ID    = 7'd1;
    localparam logic [POS_W-1:0] POS_CODE  = 7'd2;
    localparam logic [POS_W-1:0] POS_ERR0  = 7'd3;
    localparam logic [POS_W-1:0] POS_ERR1  = 7'd4;
    localparam logic [POS_W-1:0] POS_ERR2  = 7'd5;
    localparam logic [POS_W-1:0] POS_TEXT  = 7'd4;

    localparam logic [7:0] HDR_ID     = 8'h06;
    localparam logic [7:0] CODE_A     = 8'h82;
    localparam logic [7:0] CODE_B     = 8'h83;
    localparam logic [7:0] CODE_C     = 8'h87;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [SUM_W-1:0] INT_SCALE = 36'd10000;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_TOO_SHORT  = 3'd1,
        STATUS_BAD_HEADER = 3'd2,
        STATUS_DEV_ERROR  = 3'd3,
        STATUS_NO_DIGITS  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_E    = 2'd1,
        ERR_ER   = 2'd2,
        ERR_ERR  = 2'd3
    } err_match_t;

    typedef struct packed {
        logic              collecting;
        logic [CNT_W-1:0]  char_count;
        logic              dot_seen;
        logic [FRAC_W-1:0] frac_digits;
        logic [ACC_W-1:0]  accumulator;
        logic              saturated;
    } num_state_t;

    localparam num_state_t NUM_RESET = '{
        collecting:  1'b1,
        char_count:  '0,
        dot_seen:    1'b0,
        frac_digits: '0,
        accumulator: '0,
        saturated:   1'b0
    };

    function automatic logic [13:0] frac_weight(input logic [1:0] idx);
        logic [13:0] w;
        case (idx)
            2'd0:    w = 14'd1000;
            2'd1:    w = 14'd100;
            2'd2:    w = 14'd10;
            default: w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

FILE: design/rfp_char_parse.sv
// Distance text collector: folds one frame character into the fixed point
// value (0.1 mm units) with saturation. Combinational. Uses rfp_pkg.
module rfp_char_parse import rfp_pkg::*; (
    input  logic       en,
    input  logic [7:0] ch,
    input  num_state_t cur,
    output num_state_t nxt
);

    logic             is_digit;
    logic [7:0]       ch_off;
    logic [SUM_W-1:0] digit_ext;
    logic [SUM_W-1:0] acc_ext;
    logic [SUM_W-1:0] sum;
    logic             add_en;

    assign is_digit  = ch inside {[CHAR_ZERO:CHAR_NINE]};
    assign ch_off    = ch - CHAR_ZERO;
    assign digit_ext = {{(SUM_W-4){1'b0}}, ch_off[3:0]};
    assign acc_ext   = {{(SUM_W-ACC_W){1'b0}}, cur.accumulator};

    always_comb begin
        nxt    = cur;
        sum    = '0;
        add_en = 1'b0;
        if (en && cur.collecting) begin
            if (cur.char_count >= MAX_CHARS) begin
                nxt.collecting = 1'b0;
            end else if (!is_digit && ch != CHAR_DOT) begin
                nxt.collecting = 1'b0;
            end else begin
                nxt.char_count = cur.char_count + 4'd1;
                if (ch == CHAR_DOT) begin
                    // second dot closes the number
                    if (cur.dot_seen) begin
                        nxt.frac_digits = FRAC_LIMIT;
                    end
                    nxt.dot_seen = 1'b1;
                end else if (!cur.dot_seen) begin
                    sum    = (acc_ext << 3) + (acc_ext << 1) + digit_ext * INT_SCALE;
                    add_en = 1'b1;
                end else if (cur.frac_digits < FRAC_LIMIT) begin
                    sum    = acc_ext + digit_ext *
                             {{(SUM_W-14){1'b0}}, frac_weight(cur.frac_digits[1:0])};
                    add_en = 1'b1;
                    nxt.frac_digits = cur.frac_digits + 3'd1;
                end
            end
        end
        if (add_en && !cur.saturated) begin
            if (sum[SUM_W-1:ACC_W] != '0) begin
                nxt.saturated   = 1'b1;
                nxt.accumulator = '1;
            end else begin
                nxt.accumulator = sum[ACC_W-1:0];
            end
        end
    end

endmodule

FILE: design/range_frame_parser_unit.sv
// Range frame parser top level: one frame byte per transaction, one result per frame.
// Latency: result valid on the cycle after the last byte is accepted.
// Throughput: one byte per cycle; the output register decouples the sides,
// so a byte is taken whenever the result register is empty or being drained.
// Reset: synchronous active-low aresetn clears frame state and the output valid.
// Depends on rfp_pkg and rfp_char_parse.
module range_frame_parser_unit import rfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] distance_tenth_mm, [39:32] msg_code,
                                   // [47:40] device_addr
    output logic [2:0]  m_tuser    // [2:0] status
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       pend_reg, pend_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       code_reg, code_next;
    logic             hdr_ok_reg, hdr_ok_next;
    err_match_t       err_reg, err_next;
    num_state_t       num_reg, num_next, num_upd;

    logic             m_valid_reg, m_valid_next;
    logic [ACC_W-1:0] dist_reg, dist_next;
    status_t          status_reg, status_next;
    logic [7:0]       msg_reg, msg_next;
    logic [7:0]       dev_reg, dev_next;

    logic accept;
    logic in_range;
    logic char_en;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_range = pos_reg < MAX_FRAME;
    assign char_en  = accept && in_range && (pos_reg >= POS_TEXT);

    rfp_char_parse u_char (
        .en  (char_en),
        .ch  (pend_reg),
        .cur (num_reg),
        .nxt (num_upd)
    );

    always_comb begin
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        addr_next   = addr_reg;
        code_next   = code_reg;
        hdr_ok_next = hdr_ok_reg;
        err_next    = err_reg;
        num_next    = num_reg;
        if (accept && in_range) begin
            num_next  = num_upd;
            pend_next = s_tdata;
            pos_next  = pos_reg + 7'd1;
            case (pos_reg)
                POS_ADDR: addr_next = s_tdata;
                POS_ID:   hdr_ok_next = (s_tdata == HDR_ID);
                POS_CODE: begin
                    code_next   = s_tdata;
                    hdr_ok_next = hdr_ok_reg && (s_tdata inside {CODE_A, CODE_B, CODE_C});
                end
                POS_ERR0: err_next = (s_tdata == CHAR_E) ? ERR_E : ERR_NONE;
                POS_ERR1: err_next = (err_reg == ERR_E && s_tdata == CHAR_R) ? ERR_ER
                                                                              : ERR_NONE;
                POS_ERR2: err_next = (err_reg == ERR_ER && s_tdata == CHAR_R) ? ERR_ERR
                                                                               : ERR_NONE;
                default: ;
            endcase
        end
    end

    always_comb begin
        dist_next = '0;
        if (pos_next < MIN_FRAME) begin
            status_next = STATUS_TOO_SHORT;
        end else if (!hdr_ok_next) begin
            status_next = STATUS_BAD_HEADER;
        end else if (err_next == ERR_ERR) begin
            status_next = STATUS_DEV_ERROR;
        end else if (num_next.char_count == '0) begin
            status_next = STATUS_NO_DIGITS;
        end else begin
            status_next = STATUS_OK;
            dist_next   = num_next.accumulator;
        end
        msg_next = code_next;
        dev_next = addr_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept && s_tlast) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            pend_reg    <= '0;
            addr_reg    <= '0;
            code_reg    <= '0;
            hdr_ok_reg  <= 1'b0;
            err_reg     <= ERR_NONE;
            num_reg     <= NUM_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept && s_tlast) begin
                pos_reg    <= '0;
                pend_reg   <= '0;
                addr_reg   <= '0;
                code_reg   <= '0;
                hdr_ok_reg <= 1'b0;
                err_reg    <= ERR_NONE;
                num_reg    <= NUM_RESET;
            end else begin
                pos_reg    <= pos_next;
                pend_reg   <= pend_next;
                addr_reg   <= addr_next;
                code_reg   <= code_next;
                hdr_ok_reg <= hdr_ok_next;
                err_reg    <= err_next;
                num_reg    <= num_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            dist_reg   <= dist_next;
            status_reg <= status_next;
            msg_reg    <= msg_next;
            dev_reg    <= dev_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {dev_reg, msg_reg, dist_reg};
    assign m_tuser  = status_reg;

    a_err_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && status_reg != STATUS_OK |-> dist_reg == '0)
        else $error("nonzero distance on a rejected frame");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> m_valid_reg && pos_reg == '0)
        else $error("frame end did not produce a result or clear state");

    a_char_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        num_reg.char_count <= MAX_CHARS && num_reg.frac_digits <= FRAC_LIMIT)
        else $error("character or fraction count out of range");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_FRAME)
        else $error("byte position past frame limit");

endmodule

FILE: dv/range_frame_parser_unit_tb.sv
// Self-checking testbench for range_frame_parser_unit: drives rangefinder frame
// bytes, predicts each frame result in-line or takes it from the script, and compares it on the result stream.
// Depends on rfp_pkg and the range_frame_parser_unit RTL.
`timescale 1ns / 100ps

module range_frame_parser_unit_tb;
    import rfp_pkg::*;

    typedef struct packed {
        logic [31:0] distance;
        status_t     status;
        logic [7:0]  code;
        logic [7:0]  addr;
    } frame_result_t;

    typedef struct packed {
        logic          pinned;
        frame_result_t want;
    } pinned_result_t;

    typedef struct {
        logic [7:0]    addr;
        logic [7:0]    id;
        logic [7:0]    code;
        logic [95:0]   text;
        int            text_len;
        int            frame_len;
        logic          pinned;
        frame_result_t want;
    } frame_row_t;

    typedef logic [7:0] byte_q_t [$];

    localparam int unsigned FRAC_SCALE [4] = '{1000, 100, 10, 1};
    localparam int          RAND_BYTES     = 335;
    localparam int          HOLD_CYCLES    = 200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    range_frame_parser_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // frame parse state
    logic [POS_W-1:0] frame_pos   = '0;
    logic [7:0]       held_byte   = '0;
    logic [7:0]       frame_addr  = '0;
    logic [7:0]       frame_code  = '0;
    logic             header_good = 1'b0;
    err_match_t       err_seq     = ERR_NONE;
    num_state_t       number      = NUM_RESET;

    frame_result_t  result_q [$];
    pinned_result_t pinned_q [$];
    int             fail_count  = 0;
    int             bytes_taken = 0;
    int             frames_seen = 0;
    int             status_hits [5] = '{0, 0, 0, 0, 0};
    logic           calm        = 1'b0;
    logic           hold_req    = 1'b0;

    frame_row_t script_rows [17] = '{
        '{8'hFF, 8'h06, 8'h82, "",             0,  1, 1'b1,
          '{32'd0, STATUS_TOO_SHORT, 8'h00, 8'hFF}},
        '{8'h00, 8'h06, 8'h83, "1234",         4, 10, 1'b1,
          '{32'd0, STATUS_TOO_SHORT, 8'h83, 8'h00}},
        '{8'h01, 8'h07, 8'h82, "5.5",          3, 12, 1'b1,
          '{32'd0, STATUS_BAD_HEADER, 8'h82, 8'h01}},
        '{8'h02, 8'h06, 8'h84, "5.5",          3, 12, 1'b1,
          '{32'd0, STATUS_BAD_HEADER, 8'h84, 8'h02}},
        '{8'h03, 8'h06, 8'h83, "ERR",          3, 12, 1'b1,
          '{32'd0, STATUS_DEV_ERROR, 8'h83, 8'h03}},
        '{8'h04, 8'h06, 8'h87, "",             0, 12, 1'b1,
          '{32'd0, STATUS_NO_DIGITS, 8'h87, 8'h04}},
        '{8'h05, 8'h06, 8'h82, "123.456",      7, 11, 1'b1,
          '{32'd1234560, STATUS_OK, 8'h82, 8'h05}},
        '{8'h06, 8'h06, 8'h87, "0.000",        5, 12, 1'b1,
          '{32'd0, STATUS_OK, 8'h87, 8'h06}},
        '{8'h07, 8'h06, 8'h83, "1.234567",     8, 13, 1'b1,
          '{32'd12345, STATUS_OK, 8'h83, 8'h07}},
        '{8'h08, 8'h06, 8'h82, "1.2.3",        5, 12, 1'b0,
          '{32'd0, STATUS_OK, 8'h00, 8'h00}},
        '{8'h09, 8'h06, 8'h83, ".",            1, 11, 1'b1,
          '{32'd0, STATUS_OK, 8'h83, 8'h09}},
        '{8'h0A, 8'h06, 8'h87, "99999999999", 11, 15, 1'b1,
          '{32'hFFFF_FFFF, STATUS_OK, 8'h87, 8'h0A}},
        '{8'h0B, 8'h06, 8'h82, "123456789012", 12, 17, 1'b0,
          '{32'd0, STATUS_OK, 8'h00, 8'h00}},
        '{8'h0C, 8'h06, 8'h83, "7.5",          3, 30, 1'b0,
          '{32'd0, STATUS_OK, 8'h00, 8'h00}},
        '{8'h0D, 8'h06, 8'h82, "ERX",          3, 11, 1'b1,
          '{32'd0, STATUS_NO_DIGITS, 8'h82, 8'h0D}},
        '{8'h0E, 8'h06, 8'h87, "429496.7295", 11, 15, 1'b1,
          '{32'hFFFF_FFFF, STATUS_OK, 8'h87, 8'h0E}},
        '{8'h0F, 8'h06, 8'h82, "12345678",     8, 11, 1'b0,
          '{32'd0, STATUS_OK, 8'h00, 8'h00}}
    };

    // Advances the frame parse by one byte; returns 1 with the frame result on frame end.
    function automatic logic parse_frame_byte(input logic [7:0] b, input logic last,
                                              output frame_result_t res);
        logic [63:0] sum;
        logic        do_add;
        logic [7:0]  c;
        logic [3:0]  dgt;
        res = '0;
        if (frame_pos < MAX_FRAME) begin
            if (frame_pos >= POS_TEXT && number.collecting) begin
                c = held_byte;
                do_add = 1'b0;
                sum = '0;
                if (number.char_count >= MAX_CHARS
                        || !((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_DOT)) begin
                    number.collecting = 1'b0;
                end else begin
                    number.char_count = number.char_count + 4'd1;
                    if (c == CHAR_DOT) begin
                        // a second dot closes the number
                        if (number.dot_seen) number.frac_digits = FRAC_LIMIT;
                        number.dot_seen = 1'b1;
                    end else begin
                        dgt = 4'(c - CHAR_ZERO);
                        if (!number.dot_seen) begin
                            sum = 64'(number.accumulator) * 10 + 64'(dgt) * 10000;
                            do_add = 1'b1;
                        end else if (number.frac_digits < FRAC_LIMIT) begin
                            sum = 64'(number.accumulator)
                                + 64'(dgt) * 64'(FRAC_SCALE[number.frac_digits[1:0]]);
                            number.frac_digits = number.frac_digits + 3'd1;
                            do_add = 1'b1;
                        end
                        if (do_add && !number.saturated) begin
                            if (sum > 64'hFFFF_FFFF) begin
                                number.saturated   = 1'b1;
                                number.accumulator = '1;
                            end else begin
                                number.accumulator = sum[31:0];
                            end
                        end
                    end
                end
            end
            case (frame_pos)
                POS_ADDR: frame_addr = b;
                POS_ID:   header_good = (b == HDR_ID);
                POS_CODE: begin
                    frame_code  = b;
                    header_good = header_good && (b inside {CODE_A, CODE_B, CODE_C});
                end
                POS_ERR0: err_seq = (b == CHAR_E) ? ERR_E : ERR_NONE;
                POS_ERR1: err_seq = (err_seq == ERR_E && b == CHAR_R) ? ERR_ER : ERR_NONE;
                POS_ERR2: err_seq = (err_seq == ERR_ER && b == CHAR_R) ? ERR_ERR : ERR_NONE;
                default: ;
            endcase
            held_byte = b;
            frame_pos = frame_pos + 7'd1;
        end
        if (!last) return 1'b0;
        res.code = frame_code;
        res.addr = frame_addr;
        if (frame_pos < MIN_FRAME)          res.status = STATUS_TOO_SHORT;
        else if (!header_good)              res.status = STATUS_BAD_HEADER;
        else if (err_seq == ERR_ERR)        res.status = STATUS_DEV_ERROR;
        else if (number.char_count == '0)   res.status = STATUS_NO_DIGITS;
        else begin
            res.status   = STATUS_OK;
            res.distance = number.accumulator;
        end
        frame_pos   = '0;
        held_byte   = '0;
        frame_addr  = '0;
        frame_code  = '0;
        header_good = 1'b0;
        err_seq     = ERR_NONE;
        number      = NUM_RESET;
        return 1'b1;
    endfunction

    // result check first, then prediction of the byte taken on the same edge
    always @(posedge aclk) begin
        frame_result_t  got;
        frame_result_t  want;
        pinned_result_t pin;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.distance = m_tdata[31:0];
                got.code     = m_tdata[39:32];
                got.addr     = m_tdata[47:40];
                got.status   = status_t'(m_tuser);
                frames_seen++;
                if (m_tuser < 3'd5) status_hits[m_tuser]++;
                if (result_q.size() == 0) begin
                    $error("unexpected result transaction: status %0d dist %0h",
                           m_tuser, got.distance);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got.distance !== want.distance) begin
                        $error("distance_tenth_mm: expected %0h, got %0h",
                               want.distance, got.distance);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.code !== want.code) begin
                        $error("msg_code: expected %0h, got %0h", want.code, got.code);
                        fail_count++;
                    end
                    if (got.addr !== want.addr) begin
                        $error("device_addr: expected %0h, got %0h", want.addr, got.addr);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_taken++;
                if (parse_frame_byte(s_tdata, s_tlast, want)) begin
                    if (pinned_q.size() != 0) begin
                        pin = pinned_q.pop_front();
                        if (pin.pinned) want = pin.want;
                    end
                    result_q.push_back(want);
                end
            end
        end
    end

    // result side: random backpressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= calm || ($urandom_range(99) >= 31);
        end
    end

    task automatic send_frame(input byte_q_t fr);
        for (int i = 0; i < fr.size(); i++) begin
            if (!calm) begin
                while ($urandom_range(99) < 31) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= fr[i];
            s_tlast  <= (i == fr.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
    endtask

    function automatic byte_q_t build_random_frame();
        byte_q_t fr;
        int      kind;
        int      len;
        int      n;
        logic    nines;
        kind  = $urandom_range(99);
        nines = ($urandom_range(7) == 0);
        len   = $urandom_range(11, 20);
        if ($urandom_range(15) == 0) len = $urandom_range(21, 40);
        fr.push_back(8'($urandom_range(255)));
        if (kind < 78) begin
            fr.push_back(HDR_ID);
            case ($urandom_range(2))
                0:       fr.push_back(CODE_A);
                1:       fr.push_back(CODE_B);
                default: fr.push_back(CODE_C);
            endcase
        end else begin
            fr.push_back(($urandom_range(1) == 0) ? HDR_ID : 8'($urandom_range(255)));
            fr.push_back(8'($urandom_range(255)));
        end
        if (kind >= 60 && kind < 68) begin
            fr.push_back(CHAR_E);
            fr.push_back(CHAR_R);
            fr.push_back(CHAR_R);
            if ($urandom_range(2) == 0) fr[$urandom_range(5, 3)] = 8'($urandom_range(255));
        end else if (kind < 90) begin
            n = $urandom_range(7);
            repeat (n) fr.push_back(nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(3) != 0) begin
                fr.push_back(CHAR_DOT);
                repeat ($urandom_range(6))
                    fr.push_back(nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(7) == 0) begin
                    fr.push_back(CHAR_DOT);
                    repeat ($urandom_range(3)) fr.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                end
            end
        end
        if (kind >= 78 && kind < 86) len = $urandom_range(1, 10);
        if (kind >= 90) len = $urandom_range(1, 30);
        while (fr.size() < len - 1) fr.push_back(8'($urandom_range(255)));
        while (fr.size() > len - 1) void'(fr.pop_back());
        fr.push_back(8'($urandom_range(255)));
        return fr;
    endfunction

    initial begin
        byte_q_t fr;
        int      rand_bytes;
        logic    hold_done;
        rand_bytes = 0;
        hold_done  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script_rows[r]) begin
            fr = {script_rows[r].addr, script_rows[r].id, script_rows[r].code};
            for (int k = 0; k < script_rows[r].text_len; k++)
                fr.push_back(script_rows[r].text[8*(script_rows[r].text_len-1-k) +: 8]);
            while (fr.size() < script_rows[r].frame_len - 1) fr.push_back(8'h20);
            while (fr.size() > script_rows[r].frame_len - 1) void'(fr.pop_back());
            fr.push_back(8'hFF);
            pinned_q.push_back('{script_rows[r].pinned, script_rows[r].want});
            send_frame(fr);
        end

        while (rand_bytes < RAND_BYTES) begin
            calm = (rand_bytes >= 80 && rand_bytes < 180);
            if (!hold_done && rand_bytes >= 230) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            fr = build_random_frame();
            pinned_q.push_back('{1'b0, frame_result_t'('0)});
            send_frame(fr);
            rand_bytes += fr.size();
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("%0d frame bytes taken, %0d frame results compared", bytes_taken, frames_seen);
        $display("status mix: ok %0d, short %0d, bad header %0d, device error %0d, no digits %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
